// ===== src/bchel_pkg.sv =====
`timescale 1ns / 1ps

package bchel_pkg;

    localparam int FIELD_BITS = 10;
    localparam int CORRECTION = 60;
    localparam int NSYN       = 2 * CORRECTION;
    localparam int IDX_W      = $clog2(CORRECTION + 1);
    localparam int ADDR_W     = $clog2(NSYN);
    localparam int DEG_W      = $clog2(4 * CORRECTION + 1);
    localparam int INV_STEPS  = FIELD_BITS - 1;
    localparam int STEP_W     = $clog2(FIELD_BITS);

    localparam int SYN_W  = 10;
    localparam int POLY_W = 11;
    localparam int CIDX_W = 6;
    localparam int DEGO_W = 8;

    localparam logic [POLY_W-1:0] POLY_RESET = 11'd1033;

    typedef logic [FIELD_BITS-1:0] felem_t;

    typedef struct packed {
        logic              load_we;
        logic [ADDR_W-1:0] load_addr;
        logic              init;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              inv_start;
        logic              d_from_mem;
        logic              inv_sq;
        logic              inv_mul;
        logic              scale;
        logic              decide;
        logic              pass1;
        logic              upd_en;
        logic              sp_zero;
        logic              d_clear;
        logic              pass2;
        logic              acc_en;
        logic              rotate_out;
        logic [IDX_W-1:0]  mu;
    } dp_cmd_t;

    function automatic felem_t gf_mul(felem_t a, felem_t b, felem_t poly);
        felem_t p;
        p = '0;
        for (int k = FIELD_BITS - 1; k >= 0; k--) begin
            if (p[FIELD_BITS-1]) begin
                p = felem_t'(p << 1) ^ poly;
            end else begin
                p = felem_t'(p << 1);
            end
            if (b[k]) begin
                p = p ^ a;
            end
        end
        return p;
    endfunction

endpackage

// ===== src/bch_error_locator_berlekamp.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Ports                                      Content
// s_       in         s_valid s_ready s_syndrome_value          one syndrome per item
// m_       out        m_valid m_ready m_coeff_index m_coeff_value
//                     m_locator_degree m_last_coeff              one coefficient per item
// cfg_     in         cfg_valid cfg_ready cfg_data               field polynomial
//
// Syndromes load one per cycle while s_ready is high. After the last one the run takes CORRECTION
// rounds (the last skips the discrepancy pass); a single shared field multiplier serves the
// inverse, the update and the sum in turn.
// The next word's syndromes may load while coefficients are being delivered.
// Reset is synchronous and active low; it restores the default field polynomial.
// A stalled result holds the block in its output phase until taken.

module bch_error_locator_berlekamp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bchel_pkg::SYN_W-1:0]   s_syndrome_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bchel_pkg::CIDX_W-1:0]  m_coeff_index,
    output logic [bchel_pkg::SYN_W-1:0]   m_coeff_value,
    output logic [bchel_pkg::DEGO_W-1:0]  m_locator_degree,
    output logic                          m_last_coeff,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bchel_pkg::POLY_W-1:0]  cfg_data
);
    import bchel_pkg::*;

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    bchel_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .coeff_index (m_coeff_index),
        .last_coeff  (m_last_coeff),
        .cmd         (cmd)
    );

    bchel_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_poly    (cfg_data),
        .syn_in      (s_syndrome_value),
        .coeff_value (m_coeff_value),
        .degree      (m_locator_degree)
    );

endmodule

// ===== src/bchel_ctrl.sv =====
`timescale 1ns / 1ps

module bchel_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [bchel_pkg::CIDX_W-1:0] coeff_index,
    output logic              last_coeff,
    output bchel_pkg::dp_cmd_t cmd
);
    import bchel_pkg::*;

    localparam logic [3:0] ST_LOAD   = 4'd0;
    localparam logic [3:0] ST_INIT   = 4'd1;
    localparam logic [3:0] ST_INVST  = 4'd2;
    localparam logic [3:0] ST_SQ     = 4'd3;
    localparam logic [3:0] ST_MUL    = 4'd4;
    localparam logic [3:0] ST_SCALE  = 4'd5;
    localparam logic [3:0] ST_DECIDE = 4'd6;
    localparam logic [3:0] ST_PASS1  = 4'd7;
    localparam logic [3:0] ST_PREP2  = 4'd8;
    localparam logic [3:0] ST_PASS2  = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(CORRECTION);
    localparam logic [IDX_W-1:0]  MU_LAST   = IDX_W'(CORRECTION - 1);
    localparam logic [ADDR_W-1:0] LOAD_LAST = ADDR_W'(NSYN - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(INV_STEPS - 1);

    logic [3:0]        state_reg, state_next;
    logic [IDX_W-1:0]  mu_reg, mu_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ADDR_W-1:0] load_reg, load_next;

    logic [IDX_W:0]   top_raw;
    logic [IDX_W:0]   top_w;
    logic [IDX_W:0]   idx_w;
    logic [IDX_W+1:0] addr_next_w;
    logic [IDX_W+1:0] addr_first_w;
    logic             load_fire;

    assign top_raw      = {mu_reg, 1'b1};
    assign top_w        = (top_raw > (IDX_W + 1)'(CORRECTION)) ? (IDX_W + 1)'(CORRECTION)
                                                                : top_raw;
    assign idx_w        = {1'b0, idx_reg};
    assign addr_first_w = {mu_reg, 1'b0} + (IDX_W + 2)'(2);
    assign addr_next_w  = {1'b0, mu_reg, 1'b1} - {2'b00, idx_reg};

    assign s_ready   = (state_reg == ST_LOAD) ||
                       ((state_reg == ST_OUT) && (load_reg != LOAD_LAST));
    assign load_fire = s_valid && s_ready;
    assign m_valid   = (state_reg == ST_OUT);
    assign coeff_index = CIDX_W'(idx_reg);
    assign last_coeff  = (idx_reg == IDX_LAST);

    always_comb begin
        state_next = state_reg;
        mu_next    = mu_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        load_next  = load_reg;
        cmd        = '0;
        cmd.mu        = mu_reg;
        cmd.load_addr = load_reg;
        cmd.load_we   = load_fire;
        cmd.upd_en    = (idx_reg != '0) && (idx_w <= top_w);
        cmd.acc_en    = (idx_w <= top_w);
        cmd.sp_zero   = (idx_w < (IDX_W + 1)'(2));

        if (load_fire) begin
            if (load_reg == LOAD_LAST) begin
                load_next  = '0;
                state_next = ST_INIT;
            end else begin
                load_next = load_reg + ADDR_W'(1);
            end
        end

        unique case (state_reg)
            ST_LOAD: begin
            end
            ST_INIT: begin
                cmd.init    = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = '0;
                mu_next     = '0;
                state_next  = ST_INVST;
            end
            ST_INVST: begin
                cmd.inv_start  = 1'b1;
                cmd.d_from_mem = (mu_reg == '0);
                step_next      = '0;
                state_next     = ST_SQ;
            end
            ST_SQ: begin
                cmd.inv_sq = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.inv_mul = 1'b1;
                step_next   = step_reg + STEP_W'(1);
                state_next  = (step_reg == STEP_LAST) ? ST_SCALE : ST_SQ;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                idx_next   = '0;
                state_next = ST_PASS1;
            end
            ST_PASS1: begin
                cmd.pass1 = 1'b1;
                idx_next  = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_LAST) begin
                    idx_next   = '0;
                    state_next = (mu_reg == MU_LAST) ? ST_OUT : ST_PREP2;
                end
            end
            ST_PREP2: begin
                cmd.d_clear = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = addr_first_w[ADDR_W-1:0];
                state_next  = ST_PASS2;
            end
            ST_PASS2: begin
                cmd.pass2   = 1'b1;
                cmd.rd_en   = (idx_w < top_w);
                cmd.rd_addr = addr_next_w[ADDR_W-1:0];
                idx_next    = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_LAST) begin
                    idx_next   = '0;
                    mu_next    = mu_reg + IDX_W'(1);
                    state_next = ST_INVST;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    cmd.rotate_out = 1'b1;
                    idx_next       = idx_reg + IDX_W'(1);
                    if (idx_reg == IDX_LAST) begin
                        idx_next   = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            mu_reg    <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
            load_reg  <= '0;
        end else begin
            state_reg <= state_next;
            mu_reg    <= mu_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            load_reg  <= load_next;
        end
    end

endmodule

// ===== src/bchel_dpath.sv =====
`timescale 1ns / 1ps

module bchel_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bchel_pkg::dp_cmd_t            cmd,
    input  logic                          cfg_we,
    input  logic [bchel_pkg::POLY_W-1:0]  cfg_poly,
    input  logic [bchel_pkg::SYN_W-1:0]   syn_in,
    output logic [bchel_pkg::SYN_W-1:0]   coeff_value,
    output logic [bchel_pkg::DEGO_W-1:0]  degree
);
    import bchel_pkg::*;

    felem_t poly_reg;
    felem_t syn_mem [NSYN];
    felem_t rdata_reg;
    felem_t loc_reg [CORRECTION + 1];
    felem_t sp_reg  [CORRECTION + 1];
    felem_t dl1_reg, dl2_reg, ds1_reg, ds2_reg;
    felem_t d_reg, dp_reg, base_reg, r_reg, scale_reg;
    logic   grows_reg;
    logic [DEG_W-1:0] deg_reg, degp_reg, tr1_reg;

    felem_t mul_a, mul_b, prod, inv_val, loc_head, sp_head;
    logic [DEG_W-1:0] grow_to;
    logic [15:0]      deg_wide;
    logic             grows;

    assign inv_val = (dp_reg == '0) ? '0 : r_reg;
    assign grow_to = DEG_W'({cmd.mu, 1'b1}) - tr1_reg + degp_reg;
    assign grows   = (d_reg != '0) && (grow_to > deg_reg);

    always_comb begin
        if (cmd.inv_sq) begin
            mul_a = base_reg;
            mul_b = base_reg;
        end else if (cmd.inv_mul) begin
            mul_a = r_reg;
            mul_b = base_reg;
        end else if (cmd.scale) begin
            mul_a = d_reg;
            mul_b = inv_val;
        end else if (cmd.pass1) begin
            mul_a = scale_reg;
            mul_b = sp_reg[0];
        end else begin
            mul_a = loc_reg[0];
            mul_b = rdata_reg;
        end
        prod = gf_mul(mul_a, mul_b, poly_reg);
    end

    assign loc_head = cmd.upd_en ? (loc_reg[0] ^ prod) : loc_reg[0];
    assign sp_head  = cmd.sp_zero ? '0 : (grows_reg ? dl2_reg : ds2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg <= felem_t'(POLY_RESET);
        end else if (cfg_we) begin
            poly_reg <= felem_t'(cfg_poly);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_we) begin
            syn_mem[cmd.load_addr] <= felem_t'(syn_in);
        end
        if (cmd.rd_en) begin
            rdata_reg <= syn_mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            for (int j = 0; j <= CORRECTION; j++) begin
                loc_reg[j] <= (j == 0) ? felem_t'(1) : '0;
                sp_reg[j]  <= (j == 1) ? felem_t'(1) : '0;
            end
            deg_reg  <= '0;
            degp_reg <= '0;
            tr1_reg  <= '0;
            dp_reg   <= felem_t'(1);
        end else if (cmd.pass1) begin
            for (int j = 0; j < CORRECTION; j++) begin
                loc_reg[j] <= loc_reg[j+1];
                sp_reg[j]  <= sp_reg[j+1];
            end
            loc_reg[CORRECTION] <= loc_head;
            sp_reg[CORRECTION]  <= sp_head;
            dl1_reg <= loc_reg[0];
            dl2_reg <= dl1_reg;
            ds1_reg <= sp_reg[0];
            ds2_reg <= ds1_reg;
        end else if (cmd.pass2 || cmd.rotate_out) begin
            for (int j = 0; j < CORRECTION; j++) begin
                loc_reg[j] <= loc_reg[j+1];
            end
            loc_reg[CORRECTION] <= loc_reg[0];
        end

        if (cmd.inv_start) begin
            base_reg <= dp_reg;
            r_reg    <= felem_t'(1);
            if (cmd.d_from_mem) begin
                d_reg <= rdata_reg;
            end
        end
        if (cmd.inv_sq) begin
            base_reg <= prod;
        end
        if (cmd.inv_mul) begin
            r_reg <= prod;
        end
        if (cmd.scale) begin
            scale_reg <= prod;
        end
        if (cmd.decide) begin
            grows_reg <= grows;
            if (grows) begin
                deg_reg  <= grow_to;
                tr1_reg  <= DEG_W'({cmd.mu, 1'b1});
                dp_reg   <= d_reg;
                degp_reg <= deg_reg;
            end
        end
        if (cmd.d_clear) begin
            d_reg <= '0;
        end else if (cmd.pass2 && cmd.acc_en) begin
            d_reg <= d_reg ^ prod;
        end
    end

    assign deg_wide    = 16'(deg_reg);
    assign degree      = (deg_wide > 16'd255) ? 8'hFF : deg_wide[7:0];
    assign coeff_value = SYN_W'(loc_reg[0]);

endmodule

// ===== src/bchel_checker.sv =====
`timescale 1ns / 1ps

module bchel_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [bchel_pkg::CIDX_W-1:0]  m_coeff_index,
    input logic [bchel_pkg::SYN_W-1:0]   m_coeff_value,
    input logic                          m_last_coeff
);
    import bchel_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_coeff_index)))
        else $error("result dropped or changed while stalled");

    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_coeff) |=>
        (m_valid && (m_coeff_index == CIDX_W'($past(m_coeff_index) + 1'b1))))
        else $error("coefficient index out of sequence");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_coeff) |-> (m_coeff_index == CIDX_W'(CORRECTION)))
        else $error("last flag on wrong coefficient");

    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_coeff) |=> !m_valid)
        else $error("results continue after the last coefficient");

    a_const: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_coeff_index == '0)) |-> (m_coeff_value == SYN_W'(1)))
        else $error("constant term of locator is not one");

endmodule

bind bch_error_locator_berlekamp bchel_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_coeff_index (m_coeff_index),
    .m_coeff_value (m_coeff_value),
    .m_last_coeff  (m_last_coeff)
);

// ===== sim/tb_bch_error_locator_berlekamp.sv =====
`timescale 1ns / 1ps

module tb_bch_error_locator_berlekamp;
    import bchel_pkg::*;

    localparam int STALL_LIMIT = 60000;

    typedef struct packed {
        logic [CIDX_W-1:0] index;
        logic [SYN_W-1:0]  value;
        logic [DEGO_W-1:0] degree;
        logic              last;
    } coeff_item_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [SYN_W-1:0]    s_syndrome_value;
    logic                m_valid;
    logic                m_ready;
    logic [CIDX_W-1:0]   m_coeff_index;
    logic [SYN_W-1:0]    m_coeff_value;
    logic [DEGO_W-1:0]   m_locator_degree;
    logic                m_last_coeff;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [POLY_W-1:0]   cfg_data;

    coeff_item_t         coeff_queue[$];
    logic [SYN_W-1:0]    syndromes[NSYN];
    logic [SYN_W-1:0]    alpha_pow[1023];
    logic [POLY_W-1:0]   poly_now;
    int                  load_pos;
    int                  mismatches;
    int                  quiet_cycles;
    bit                  calm;

    bch_error_locator_berlekamp u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_syndrome_value (s_syndrome_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_coeff_index    (m_coeff_index),
        .m_coeff_value    (m_coeff_value),
        .m_locator_degree (m_locator_degree),
        .m_last_coeff     (m_last_coeff),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [SYN_W-1:0] gf_times(logic [SYN_W-1:0] a, logic [SYN_W-1:0] b,
                                                  logic [POLY_W-1:0] poly);
        logic [2*SYN_W-1:0] p;
        logic [2*SYN_W-1:0] full;
        p = '0;
        full = {{(SYN_W-1){1'b0}}, 1'b1, poly[SYN_W-1:0]};
        for (int i = 0; i < SYN_W; i++) begin
            if (b[i]) begin
                p = p ^ ({{SYN_W{1'b0}}, a} << i);
            end
        end
        for (int i = 2 * SYN_W - 2; i >= SYN_W; i--) begin
            if (p[i]) begin
                p = p ^ (full << (i - SYN_W));
            end
        end
        return p[SYN_W-1:0];
    endfunction

    function automatic logic [SYN_W-1:0] gf_recip(logic [SYN_W-1:0] a, logic [POLY_W-1:0] poly);
        logic [SYN_W-1:0] r;
        logic [SYN_W-1:0] base;
        r = SYN_W'(1);
        base = a;
        for (int i = 1; i < SYN_W; i++) begin
            base = gf_times(base, base, poly);
            r = gf_times(r, base, poly);
        end
        return (base == '0) ? '0 : r;
    endfunction

    // Runs the fixed-round Berlekamp pass on the stored syndromes and queues the coefficients.
    task automatic solve_locator();
        logic [SYN_W-1:0] sigma[CORRECTION+1];
        logic [SYN_W-1:0] shifted[CORRECTION+1];
        logic [SYN_W-1:0] saved[CORRECTION+1];
        logic [SYN_W-1:0] disc;
        logic [SYN_W-1:0] disc_prev;
        logic [SYN_W-1:0] scale;
        int               rho2;
        int               deg;
        int               deg_prev;
        int               deg_saved;
        int               top;
        int               grow_to;
        bit               grows;
        coeff_item_t      c;
        for (int i = 0; i <= CORRECTION; i++) begin
            sigma[i] = '0;
            shifted[i] = '0;
            saved[i] = '0;
        end
        sigma[0] = SYN_W'(1);
        shifted[1] = SYN_W'(1);
        deg = 0;
        deg_prev = 0;
        rho2 = -1;
        disc_prev = SYN_W'(1);
        disc = syndromes[0];
        for (int mu = 0; mu < CORRECTION; mu++) begin
            for (int i = 0; i < CORRECTION - 1; i++) saved[i] = sigma[i];
            deg_saved = deg;
            scale = gf_times(disc, gf_recip(disc_prev, poly_now), poly_now);
            top = (2 * mu + 1 > CORRECTION) ? CORRECTION : 2 * mu + 1;
            for (int i = 1; i <= top; i++) sigma[i] ^= gf_times(scale, shifted[i], poly_now);
            grow_to = 2 * mu - rho2 + deg_prev;
            grows = (disc != '0) && (grow_to > deg);
            if (grows) deg = grow_to;
            if (mu == CORRECTION - 1) break;
            if (grows) begin
                rho2 = 2 * mu;
                disc_prev = disc;
                deg_prev = deg_saved;
            end
            for (int i = CORRECTION - 1; i >= 1; i--) begin
                shifted[i+1] = grows ? saved[i-1] : shifted[i-1];
            end
            shifted[1] = '0;
            shifted[0] = '0;
            disc = syndromes[2*mu+2];
            for (int i = 1; i <= top; i++) begin
                disc ^= gf_times(sigma[i], syndromes[2*mu+2-i], poly_now);
            end
        end
        for (int k = 0; k <= CORRECTION; k++) begin
            c.index = CIDX_W'(k);
            c.value = sigma[k];
            c.degree = (deg > 255) ? 8'd255 : deg[7:0];
            c.last = (k == CORRECTION);
            coeff_queue.push_back(c);
        end
    endtask

    task automatic send_syndrome(input logic [SYN_W-1:0] v);
        if (!calm) begin
            while ($urandom_range(99) < 24) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_syndrome_value <= v;
        do @(posedge aclk); while (!s_ready);
        syndromes[load_pos] = v;
        load_pos++;
        if (load_pos == NSYN) begin
            load_pos = 0;
            solve_locator();
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (coeff_queue.size() != 0) @(posedge aclk);
    endtask

    task automatic write_poly(input logic [POLY_W-1:0] poly);
        drain();
        repeat (20) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= poly;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        poly_now = poly;
    endtask

    task automatic send_error_word(input int errors);
        int pos[$];
        logic [SYN_W-1:0] s;
        for (int e = 0; e < errors; e++) pos.push_back($urandom_range(1022));
        for (int j = 1; j <= NSYN; j++) begin
            s = '0;
            foreach (pos[e]) s ^= alpha_pow[(j * pos[e]) % 1023];
            send_syndrome(s);
        end
    endtask

    task automatic test_zero_word();
        for (int j = 0; j < NSYN; j++) send_syndrome('0);
    endtask

    task automatic test_full_ones();
        calm = 1'b1;
        for (int j = 0; j < NSYN; j++) send_syndrome('1);
        drain();
        calm = 1'b0;
    endtask

    task automatic test_poly_extremes();
        logic [POLY_W-1:0] polys[4];
        polys = '{11'd0, 11'h7FF, 11'd9, 11'($urandom_range(2047))};
        foreach (polys[p]) begin
            write_poly(polys[p]);
            for (int j = 0; j < NSYN; j++) send_syndrome(SYN_W'($urandom));
        end
        write_poly(POLY_RESET);
    endtask

    task automatic test_error_words();
        send_error_word(1);
        send_error_word($urandom_range(2, 30));
        drain();
        send_error_word($urandom_range(31, 60));
        send_error_word($urandom_range(61, 70));
    endtask

    task automatic test_noise();
        for (int j = 0; j < NSYN; j++) begin
            send_syndrome(($urandom_range(3) == 0) ? SYN_W'($urandom) : alpha_pow[j]);
        end
        drain();
    endtask

    always @(posedge aclk) begin
        m_ready <= (calm || !aresetn) ? 1'b1 : ($urandom_range(99) >= 24);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (coeff_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected item: index %0d value %0d", m_coeff_index,
                             m_coeff_value);
                end
            end else begin
                if ({m_coeff_index, m_coeff_value, m_locator_degree, m_last_coeff}
                        !== coeff_queue[0]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 coeff_queue[0].index, coeff_queue[0].value,
                                 coeff_queue[0].degree, coeff_queue[0].last, m_coeff_index,
                                 m_coeff_value, m_locator_degree, m_last_coeff);
                    end
                end
                void'(coeff_queue.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_syndrome_value = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        calm = 1'b0;
        load_pos = 0;
        mismatches = 0;
        quiet_cycles = 0;
        poly_now = POLY_RESET;
        alpha_pow[0] = SYN_W'(1);
        for (int i = 1; i < 1023; i++) begin
            alpha_pow[i] = gf_times(alpha_pow[i-1], SYN_W'(2), POLY_RESET);
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_zero_word();
        test_full_ones();
        test_poly_extremes();
        test_error_words();
        test_noise();
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && coeff_queue.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
